// ===== src/f2r11_pkg.sv =====
// ----------------------------------------------------------------------------
// R11G11B10 packer package
// Shared field widths and codes for the float to small-float conversion.
// ----------------------------------------------------------------------------
package f2r11_pkg;

    localparam logic [4:0] UF_EXP_INF = 5'd31;
    localparam logic [4:0] UF_EXP_MAX = 5'd30;
    localparam int RG_MANT_BITS = 6;
    localparam int B_MANT_BITS = 5;

    localparam logic [1:0] CLS_ZERO = 2'd0;
    localparam logic [1:0] CLS_INF  = 2'd1;
    localparam logic [1:0] CLS_SAT  = 2'd2;
    localparam logic [1:0] CLS_NUM  = 2'd3;

    typedef struct packed {
        logic [1:0]  cls;
        logic        denorm;
        logic [4:0]  tgt;
        logic [5:0]  dshift;
        logic [23:0] mant;
    } t_dec;

endpackage

// ===== src/f2r11_chan.sv =====
// ----------------------------------------------------------------------------
// R11G11B10 channel converter
// Converts one single-precision pattern to an unsigned small float in three
// register stages: decode, shift and round, then carry handling.
// ----------------------------------------------------------------------------
module f2r11_chan import f2r11_pkg::*; #(
    parameter int M = 6
) (
    input  logic           i_clk,
    input  logic [2:0]     i_en,
    input  logic [31:0]    i_bits,
    output logic [M+4:0]   o_code
);

    t_dec r_dec;
    t_dec n_dec;
    logic [1:0]   r_cls2;
    logic         r_den2;
    logic [4:0]   r_tgt2;
    logic [M:0]   r_rnd;
    logic [M:0]   n_rnd;
    logic [M+4:0] r_code;
    logic [M+4:0] n_code;

    always_comb begin
        logic [7:0] bexp;
        logic [8:0] tgt9;
        logic [8:0] sh9;
        bexp = i_bits[30:23];
        tgt9 = {1'b0, bexp} - 9'd112;
        sh9 = 9'd136 - 9'(M) - {1'b0, bexp};
        n_dec = '0;
        n_dec.mant = {1'b1, i_bits[22:0]};
        n_dec.tgt = tgt9[4:0];
        if (bexp == 8'hFF) begin
            n_dec.cls = (i_bits[31] || i_bits[22:0] != '0) ? CLS_ZERO : CLS_INF;
        end else if (i_bits[31] || bexp == 8'd0) begin
            n_dec.cls = CLS_ZERO;
        end else if (bexp >= 8'd143) begin
            n_dec.cls = CLS_SAT;
        end else if (bexp <= 8'd112) begin
            n_dec.cls = (sh9 > 9'd40) ? CLS_ZERO : CLS_NUM;
            n_dec.denorm = 1'b1;
            n_dec.dshift = sh9[5:0];
        end else begin
            n_dec.cls = CLS_NUM;
        end
    end

    always_comb begin
        logic [24:0] sum;
        logic [63:0] big;
        big = ({40'd0, r_dec.mant} << 1) >> r_dec.dshift;
        sum = {1'b0, r_dec.mant} + (25'd1 << (22 - M));
        if (r_dec.denorm) begin
            n_rnd = (big[63:M+2] != '0) ? {1'b1, {M{1'b0}}}
                    : (M+1)'((big[M+1:0] + 1'b1) >> 1);
        end else begin
            n_rnd = {sum[24], sum[22:23-M]};
        end
    end

    always_comb begin
        logic [4:0] e;
        n_code = '0;
        e = r_tgt2;
        case (r_cls2)
            CLS_INF: n_code = {UF_EXP_INF, {M{1'b0}}};
            CLS_SAT: n_code = {UF_EXP_MAX, {M{1'b1}}};
            CLS_NUM: begin
                if (r_den2) begin
                    n_code = (M+5)'(r_rnd);
                end else if (r_rnd[M] == 1'b0) begin
                    n_code = {e, r_rnd[M-1:0]};
                end else if (e == UF_EXP_MAX) begin
                    n_code = {UF_EXP_MAX, {M{1'b1}}};
                end else begin
                    n_code = {e + 5'd1, {M{1'b0}}};
                end
            end
            default: n_code = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dec <= n_dec;
        end
        if (i_en[1]) begin
            r_cls2 <= r_dec.cls;
            r_den2 <= r_dec.denorm;
            r_tgt2 <= r_dec.tgt;
            r_rnd <= n_rnd;
        end
        if (i_en[2]) begin
            r_code <= n_code;
        end
    end

    assign o_code = r_code;

endmodule

// ===== src/float_to_r11g11b10_packer.sv =====
// ----------------------------------------------------------------------------
// Float to R11G11B10 packer
// Packs three single-precision channels into one small-float word.
// ----------------------------------------------------------------------------
// One beat enters every cycle unless o_stall is high; each beat passes
// through the decode, round and carry stages of each channel. A stall
// holds every stage that is full and cannot drain; empty stages still fill.
module float_to_r11g11b10_packer import f2r11_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_red_bits,
    input  logic [31:0] i_green_bits,
    input  logic [31:0] i_blue_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_packed_word
);

    logic [2:0]  r_vld;
    logic [2:0]  en;
    logic [10:0] red_code;
    logic [10:0] green_code;
    logic [9:0]  blue_code;

    assign en[2] = !r_vld[2] || !i_stall;
    assign en[1] = !r_vld[1] || en[2];
    assign en[0] = !r_vld[0] || en[1];
    assign o_stall = !en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_valid;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
        end
    end

    f2r11_chan #(.M(RG_MANT_BITS)) u_red (
        .i_clk(i_clk), .i_en(en), .i_bits(i_red_bits), .o_code(red_code));
    f2r11_chan #(.M(RG_MANT_BITS)) u_green (
        .i_clk(i_clk), .i_en(en), .i_bits(i_green_bits), .o_code(green_code));
    f2r11_chan #(.M(B_MANT_BITS)) u_blue (
        .i_clk(i_clk), .i_en(en), .i_bits(i_blue_bits), .o_code(blue_code));

    assign o_valid = r_vld[2];
    assign o_packed_word = {blue_code, green_code, red_code};

endmodule

// ===== src/f2r11_checker.sv =====
// ----------------------------------------------------------------------------
// R11G11B10 packer checker
// Port-level checks of the packer pipeline behavior.
// ----------------------------------------------------------------------------
module f2r11_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_packed_word
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_packed_word))
        else $error("stalled beat changed");

    a_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("beat lost in pipeline");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");

endmodule

bind float_to_r11g11b10_packer f2r11_checker u_chk (.*);
